// File: hdl/ttlamt_pkg.sv
package ttlamt_pkg;

    localparam int KEY_W = 32;
    localparam int TTL_W = 15;
    localparam int CMD_W = 3;
    localparam int OCC_W = 7;

    localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REFRESH  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd4;

    localparam logic [TTL_W-1:0] RELOAD_RESET = 15'd120;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [TTL_W-1:0] ttl;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic update;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic addr_last;
    } status_t;

endpackage

// File: hdl/ttl_aged_membership_table_unit.sv
// An item with a used command passes through the scan, drain, update and respond states,
// and done is high in respond; an unused command code goes straight to update and respond.
// A new item is taken only after the previous one has been answered.
// Reset: asynchronous, active low; afterwards a clearing pass over every address marks
// every entry invalid while busy stays high, and reload_ttl returns to 120.
// The receiver cannot stall: each result is shown for exactly one cycle with done.

// The table keeps one entry per RAM word: a valid bit, the key and its TTL.
// Every command except an unused code scans all entries in address order.
// Add, refresh, contains and remove record the first matching slot and the
// lowest free slot during the scan, then make at most one write in a final
// update cycle. A tick rewrites each valid entry as it streams past, either
// decrementing its TTL or clearing its valid bit when the TTL is already zero.
// Because exactly one command runs at a time, busy stays high from the cycle
// after an item is accepted until the cycle after its result is shown.
// The configuration channel is always ready; the user must write reload_ttl only while
// the block is idle so a write never lands in the middle of a command; it is not enforced.
module ttl_aged_membership_table_unit
    import ttlamt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [CMD_W-1:0] cmd,
    input  logic [KEY_W-1:0] key,
    output logic             done,
    output logic             hit,
    output logic             inserted,
    output logic             dropped_full,
    output logic [OCC_W-1:0] occupancy,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [TTL_W-1:0] cfg_data
);

    ctrl_t   ctrl;
    status_t status;

    // The reload register can take a write in every cycle.
    assign cfg_ready = 1'b1;

    ttlamt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy),
        .done   (done)
    );

    ttlamt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .cmd          (cmd),
        .key          (key),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .hit          (hit),
        .inserted     (inserted),
        .dropped_full (dropped_full),
        .occupancy    (occupancy)
    );

endmodule

// File: hdl/ttlamt_ram.sv
module ttlamt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/ttlamt_ctrl.sv
module ttlamt_ctrl
    import ttlamt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CMD_W-1:0] cmd,
    input  status_t          status,
    output ctrl_t            ctrl,
    output logic             busy,
    output logic             done
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_RESPOND
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    assign accept = (state_reg == ST_IDLE) && start;

    always_comb
    begin
        ctrl.clear  = (state_reg == ST_CLEAR);
        ctrl.load   = accept;
        ctrl.scan   = (state_reg == ST_SCAN);
        ctrl.update = (state_reg == ST_UPDATE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (status.addr_last)
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        // Unused command codes skip the scan entirely.
                        if (cmd <= CMD_TICK)
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_UPDATE;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (status.addr_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    state_reg <= ST_RESPOND;
                    done_reg  <= 1'b1;
                end
                ST_RESPOND:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b0;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b0;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// File: hdl/ttlamt_datapath.sv
module ttlamt_datapath
    import ttlamt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_t            ctrl,
    output status_t          status,
    input  logic [CMD_W-1:0] cmd,
    input  logic [KEY_W-1:0] key,
    input  logic             cfg_write,
    input  logic [TTL_W-1:0] cfg_data,
    output logic             hit,
    output logic             inserted,
    output logic             dropped_full,
    output logic [OCC_W-1:0] occupancy
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CMD_W-1:0] cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [TTL_W-1:0] reload_reg;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [AW-1:0]    rd_addr_reg;
    logic             rd_pend_reg;
    logic             match_reg, match_next;
    logic [AW-1:0]    match_idx_reg, match_idx_next;
    logic             free_reg, free_next;
    logic [AW-1:0]    free_idx_reg, free_idx_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             hit_reg, hit_next;
    logic             ins_reg, ins_next;
    logic             drop_reg, drop_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    entry_t           wr_entry;
    logic [ENTRY_W-1:0] rd_data;
    entry_t           rd_entry;

    assign rd_entry = entry_t'(rd_data);
    assign status.addr_last = (addr_reg == AW'(CAPACITY - 1));

    ttlamt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (ctrl.scan),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        addr_next      = addr_reg;
        match_next     = match_reg;
        match_idx_next = match_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        count_next     = count_reg;
        hit_next       = hit_reg;
        ins_next       = ins_reg;
        drop_next      = drop_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_entry       = '0;

        if (ctrl.clear || ctrl.scan)
        begin
            addr_next = addr_reg + AW'(1);
        end
        if (ctrl.load)
        begin
            addr_next  = '0;
            match_next = 1'b0;
            free_next  = 1'b0;
        end

        if (ctrl.clear)
        begin
            wr_en = 1'b1;
        end
        else if (rd_pend_reg)
        begin
            if (cmd_reg == CMD_TICK)
            begin
                // Age one entry per cycle; an entry already at zero expires.
                if (rd_entry.valid)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = rd_addr_reg;
                    wr_entry = rd_entry;
                    if (rd_entry.ttl != '0)
                    begin
                        wr_entry.ttl = rd_entry.ttl - TTL_W'(1);
                    end
                    else
                    begin
                        wr_entry.valid = 1'b0;
                        count_next     = count_reg - CW'(1);
                    end
                end
            end
            else
            begin
                if (rd_entry.valid && (rd_entry.key == key_reg) && !match_reg)
                begin
                    match_next     = 1'b1;
                    match_idx_next = rd_addr_reg;
                end
                if (!rd_entry.valid && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = rd_addr_reg;
                end
            end
        end
        else if (ctrl.update)
        begin
            hit_next       = 1'b0;
            ins_next       = 1'b0;
            drop_next      = 1'b0;
            wr_entry.valid = 1'b1;
            wr_entry.key   = key_reg;
            wr_entry.ttl   = reload_reg;
            wr_addr        = match_idx_reg;
            unique case (cmd_reg)
                CMD_ADD:
                begin
                    if (match_reg)
                    begin
                        hit_next = 1'b1;
                        wr_en    = 1'b1;
                    end
                    else if (free_reg)
                    begin
                        ins_next   = 1'b1;
                        wr_en      = 1'b1;
                        wr_addr    = free_idx_reg;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
                CMD_REFRESH:
                begin
                    hit_next = match_reg;
                    wr_en    = match_reg;
                end
                CMD_CONTAINS:
                begin
                    hit_next = match_reg;
                end
                CMD_REMOVE:
                begin
                    hit_next       = match_reg;
                    wr_en          = match_reg;
                    wr_entry.valid = 1'b0;
                    if (match_reg)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg    <= '0;
            rd_pend_reg <= 1'b0;
            match_reg   <= 1'b0;
            free_reg    <= 1'b0;
            count_reg   <= '0;
            hit_reg     <= 1'b0;
            ins_reg     <= 1'b0;
            drop_reg    <= 1'b0;
            reload_reg  <= RELOAD_RESET;
        end
        else
        begin
            addr_reg    <= addr_next;
            rd_pend_reg <= ctrl.scan;
            match_reg   <= match_next;
            free_reg    <= free_next;
            count_reg   <= count_next;
            hit_reg     <= hit_next;
            ins_reg     <= ins_next;
            drop_reg    <= drop_next;
            if (cfg_write)
            begin
                reload_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg   <= addr_reg;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        if (ctrl.load)
        begin
            cmd_reg <= cmd;
            key_reg <= key;
        end
    end

    assign hit          = hit_reg;
    assign inserted     = ins_reg;
    assign dropped_full = drop_reg;
    assign occupancy    = OCC_W'(count_reg);

endmodule

// File: hdl/ttlamt_checker.sv
module ttlamt_checker
    import ttlamt_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input logic             hit,
    input logic             inserted,
    input logic             dropped_full,
    input logic [OCC_W-1:0] occupancy
);

    // An accepted item holds the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an item was accepted");

    // A result is only shown while an item is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done strobe outside a busy period");

    // The done strobe lasts exactly one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe lasted more than one cycle");

    // Hit, insert and full-drop outcomes exclude each other.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($countones({hit, inserted, dropped_full}) <= 1))
        else $error("conflicting result flags");

    // An insert always leaves the table non-empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && inserted) |-> (occupancy != '0))
        else $error("insert reported with zero occupancy");

endmodule

bind ttl_aged_membership_table_unit ttlamt_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .hit          (hit),
    .inserted     (inserted),
    .dropped_full (dropped_full),
    .occupancy    (occupancy)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the TTL aged membership table.
// Commands go in over the start/busy handshake and are predicted on acceptance.
// Results come back on the done strobe and are checked against the oldest
// expectation. The receiver cannot stall, so only the sender idles.
module tb_top;
    import ttlamt_pkg::*;

    localparam int SLOTS        = 64;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int KEY_POOL_N   = 128;
    localparam int IDLE_PCT     = 37;

    // Codes 5..7 are not decoded by the block; they must leave the table alone.
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_TICK + 1'b1;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = '1;

    localparam logic [TTL_W-1:0] RELOAD_MAX = '1;
    localparam logic [TTL_W-1:0] RELOAD_MIN = 15'd1;
    localparam logic [TTL_W-1:0] RELOAD_OFF = '0;

    // One result of the block, in the order the ports are checked.
    typedef struct packed {
        logic             hit;
        logic             inserted;
        logic             dropped_full;
        logic [OCC_W-1:0] occupancy;
    } table_result_t;

    // The scoreboard keeps its own copy of the table and of reload_ttl.
    // Every accepted item is applied to that copy at once, and the result it
    // yields waits in a queue until the block shows its own.
    class membership_scoreboard;
        bit               slot_valid [SLOTS];
        logic [KEY_W-1:0] slot_key   [SLOTS];
        logic [TTL_W-1:0] slot_ttl   [SLOTS];
        int               live_count;
        logic [TTL_W-1:0] reload_ttl;
        table_result_t    expected_results [$];

        int unsigned mismatches;
        int unsigned op_seen [8];
        int unsigned hits;
        int unsigned inserts;
        int unsigned refusals;
        int unsigned peak_occupancy;

        function new();
            foreach (slot_valid[i])
                slot_valid[i] = 1'b0;
            live_count     = 0;
            reload_ttl     = RELOAD_RESET;
            mismatches     = 0;
            hits           = 0;
            inserts        = 0;
            refusals       = 0;
            peak_occupancy = 0;
            foreach (op_seen[i])
                op_seen[i] = 0;
        endfunction

        function void set_reload(logic [TTL_W-1:0] value);
            reload_ttl = value;
        endfunction

        function int find_key(logic [KEY_W-1:0] k);
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i] && slot_key[i] == k)
                    return i;
            return -1;
        endfunction

        function int find_free();
            for (int i = 0; i < SLOTS; i++)
                if (!slot_valid[i])
                    return i;
            return -1;
        endfunction

        // Applies one command to the table copy and returns what the block
        // must report for it.
        function table_result_t predict_table_op(logic [CMD_W-1:0] op, logic [KEY_W-1:0] k);
            table_result_t r;
            int            s;
            r = '0;
            case (op)
                CMD_ADD:
                begin
                    s = find_key(k);
                    if (s >= 0)
                    begin
                        r.hit = 1'b1;
                        slot_ttl[s] = reload_ttl;
                    end
                    else
                    begin
                        // A new key takes the lowest free slot, or is refused.
                        s = find_free();
                        if (s >= 0)
                        begin
                            slot_valid[s] = 1'b1;
                            slot_key[s]   = k;
                            slot_ttl[s]   = reload_ttl;
                            live_count++;
                            r.inserted = 1'b1;
                        end
                        else
                            r.dropped_full = 1'b1;
                    end
                end
                CMD_REFRESH:
                begin
                    s = find_key(k);
                    if (s >= 0)
                    begin
                        r.hit = 1'b1;
                        slot_ttl[s] = reload_ttl;
                    end
                end
                CMD_CONTAINS:
                    r.hit = (find_key(k) >= 0);
                CMD_REMOVE:
                begin
                    s = find_key(k);
                    if (s >= 0)
                    begin
                        r.hit = 1'b1;
                        slot_valid[s] = 1'b0;
                        live_count--;
                    end
                end
                CMD_TICK:
                begin
                    // Entries whose TTL has already run down go away; the rest age.
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!slot_valid[i])
                            continue;
                        if (slot_ttl[i] != '0)
                            slot_ttl[i] = slot_ttl[i] - 1'b1;
                        else
                        begin
                            slot_valid[i] = 1'b0;
                            live_count--;
                        end
                    end
                end
                default:
                    ;
            endcase
            r.occupancy = OCC_W'(live_count);
            return r;
        endfunction

        function void note_command(logic [CMD_W-1:0] op, logic [KEY_W-1:0] k);
            table_result_t r;
            r = predict_table_op(op, k);
            expected_results = {expected_results, r};
            op_seen[op]++;
            hits     += r.hit;
            inserts  += r.inserted;
            refusals += r.dropped_full;
            if (live_count > peak_occupancy)
                peak_occupancy = live_count;
        endfunction

        task flag_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(table_result_t got);
            table_result_t want;
            if (expected_results.size() == 0)
            begin
                flag_mismatch($sformatf("result with nothing outstanding: %p", got));
                return;
            end
            want = expected_results.pop_front();
            if (got.hit !== want.hit)
                flag_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
            if (got.inserted !== want.inserted)
                flag_mismatch($sformatf("inserted %b, expected %b",
                                        got.inserted, want.inserted));
            if (got.dropped_full !== want.dropped_full)
                flag_mismatch($sformatf("dropped_full %b, expected %b",
                                        got.dropped_full, want.dropped_full));
            if (got.occupancy !== want.occupancy)
                flag_mismatch($sformatf("occupancy %0d, expected %0d",
                                        got.occupancy, want.occupancy));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic             done;
    logic             hit;
    logic             inserted;
    logic             dropped_full;
    logic [OCC_W-1:0] occupancy;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [TTL_W-1:0] cfg_data;

    membership_scoreboard sb;
    logic [KEY_W-1:0]     key_pool [KEY_POOL_N];
    bit                   quiet_stretch;
    int unsigned          cycle_count;

    ttl_aged_membership_table_unit #(
        .CAPACITY(SLOTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .key         (key),
        .done        (done),
        .hit         (hit),
        .inserted    (inserted),
        .dropped_full(dropped_full),
        .occupancy   (occupancy),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Results cannot be held off, so every done strobe is checked as it comes.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result('{hit, inserted, dropped_full, occupancy});
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, sb.expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The sender idles in roughly a third of its slots. Most gaps are short,
    // but some span a whole scan so that start also rises while busy is low
    // for a long time and in the middle of the clearing pass.
    function automatic int pick_gap();
        if (quiet_stretch || $urandom_range(0, 99) >= IDLE_PCT)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(5, SLOTS + 10);
        return $urandom_range(1, 3);
    endfunction

    // Inputs change on the falling edge. The item is taken at the first
    // rising edge that sees busy low, and start stays high across items
    // sent back to back.
    task automatic send_item(logic [CMD_W-1:0] op, logic [KEY_W-1:0] k);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= op;
        key   <= k;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_command(op, k);
    endtask

    // Lowers start and waits until every predicted result has come back and
    // the block has gone idle.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (sb.expected_results.size() != 0 || busy !== 1'b0)
            @(posedge clk);
    endtask

    // reload_ttl is only changed while nothing is in flight.
    task automatic write_reload(logic [TTL_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.set_reload(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Keys are mostly drawn from the first pool_n entries of a fixed pool so
    // that adds, refreshes and removes keep landing on present keys. A few
    // are fully random to exercise misses on arbitrary values.
    function automatic logic [KEY_W-1:0] pick_key(int pool_n);
        if ($urandom_range(0, 19) == 0)
            return $urandom;
        return key_pool[$urandom_range(0, pool_n - 1)];
    endfunction

    function automatic logic [CMD_W-1:0] pick_op(int add_pct, int tick_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < add_pct)
            return CMD_ADD;
        if (r < add_pct + tick_pct)
            return CMD_TICK;
        if (r >= 97)
            return CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        case ($urandom_range(0, 2))
            0:       return CMD_REFRESH;
            1:       return CMD_CONTAINS;
            default: return CMD_REMOVE;
        endcase
    endfunction

    // One random phase. Now and then the sender stops until the block has
    // caught up completely before going on.
    task automatic run_phase(int n_items, int pool_n, int add_pct, int tick_pct);
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 59) == 0)
                drain_results();
            send_item(pick_op(add_pct, tick_pct), pick_key(pool_n));
        end
    endtask

    initial
    begin
        sb            = new();
        cycle_count   = 0;
        quiet_stretch = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        cmd           = CMD_ADD;
        key           = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h0000_0001;
        for (int i = 4; i < KEY_POOL_N; i++)
            key_pool[i] = $urandom;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, with reload_ttl still at its reset value.
        // An empty table misses on everything, and a tick finds nothing to age.
        send_item(CMD_CONTAINS, 32'h0000_0000);
        send_item(CMD_REMOVE,   32'hFFFF_FFFF);
        send_item(CMD_REFRESH,  32'h0000_0000);
        send_item(CMD_TICK,     32'h0000_0000);
        // Insert the extreme keys, then hit them with every lookup command.
        send_item(CMD_ADD,      32'h0000_0000);
        send_item(CMD_ADD,      32'hFFFF_FFFF);
        send_item(CMD_ADD,      32'h0000_0000);
        send_item(CMD_REFRESH,  32'hFFFF_FFFF);
        send_item(CMD_CONTAINS, 32'hFFFF_FFFF);
        send_item(CMD_CONTAINS, 32'h8000_0000);
        // Unused codes change nothing; the tick ignores its key.
        send_item(CMD_SPARE_FIRST,              32'h0000_0000);
        send_item(CMD_SPARE_FIRST + 1'b1,       32'hFFFF_FFFF);
        send_item(CMD_SPARE_LAST,               32'h0000_0000);
        send_item(CMD_TICK,                     32'hFFFF_FFFF);
        // Removing frees slot zero, which the next new key must take again.
        send_item(CMD_REMOVE,   32'h0000_0000);
        send_item(CMD_REMOVE,   32'h0000_0000);
        send_item(CMD_ADD,      32'h5555_5555);
        send_item(CMD_ADD,      32'hAAAA_AAAA);
        send_item(CMD_CONTAINS, 32'h5555_5555);

        // A zero reload is stored as is, so the next tick erases the entry.
        write_reload(RELOAD_OFF);
        send_item(CMD_ADD,      32'h5555_5555);
        send_item(CMD_TICK,     32'h0000_0000);
        send_item(CMD_CONTAINS, 32'h5555_5555);

        // Random phases, each under its own reload setting and command mix.
        write_reload(RELOAD_RESET);
        run_phase(200, 40, 40, 10);

        // Long TTL and many distinct keys: the table fills up and refuses adds.
        write_reload(RELOAD_MAX);
        run_phase(350, 100, 70, 2);

        // Entries expire almost at once; frequent ticks keep the table churning.
        write_reload(RELOAD_OFF);
        run_phase(200, 24, 45, 25);

        // A stretch in which the sender inserts no random idle gaps.
        write_reload(RELOAD_MIN);
        quiet_stretch = 1'b1;
        run_phase(200, 24, 45, 25);
        quiet_stretch = 1'b0;

        write_reload(15'd3);
        run_phase(250, 48, 45, 15);

        write_reload(TTL_W'($urandom_range(1, RELOAD_MAX)));
        run_phase(250, KEY_POOL_N, 50, 5);

        write_reload(TTL_W'($urandom_range(0, 40)));
        run_phase(200, 64, 35, 15);

        drain_results();
        // Leave room for any stray strobe that should never have come.
        repeat (SLOTS + 10) @(posedge clk);

        $display("Covered %0d adds, %0d refreshes, %0d lookups, %0d removes, %0d ticks,",
                 sb.op_seen[CMD_ADD], sb.op_seen[CMD_REFRESH], sb.op_seen[CMD_CONTAINS],
                 sb.op_seen[CMD_REMOVE], sb.op_seen[CMD_TICK]);
        $display("%0d unused codes; saw %0d hits, %0d inserts, %0d refused adds, peak %0d.",
                 sb.op_seen[5] + sb.op_seen[6] + sb.op_seen[7],
                 sb.hits, sb.inserts, sb.refusals, sb.peak_occupancy);
        if (sb.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
hdl/ttlamt_pkg.sv
hdl/ttlamt_ram.sv
hdl/ttlamt_ctrl.sv
hdl/ttlamt_datapath.sv
hdl/ttl_aged_membership_table_unit.sv
hdl/ttlamt_checker.sv
tb/tb_top.sv
